// ===== hdl/led_ring_and_digit_frame_controller_top_defines.svh =====
// Assertion macros shared by the LED ring and digit frame controller.
`ifndef LED_RING_AND_DIGIT_FRAME_CONTROLLER_TOP_DEFINES_SVH
`define LED_RING_AND_DIGIT_FRAME_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LRDF_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRDF_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lrdf_pkg.sv =====
// Shared types, constants and the digit font of the LED ring frame controller.
`default_nettype none
package lrdf_pkg;

  localparam int FRAME_BYTES   = 12;
  localparam int RING_LEDS_DEF = 60;
  localparam int RING_MAX      = 64;
  localparam int FRAME_W       = FRAME_BYTES * 8;
  localparam int CODE_W        = 8;
  localparam int GLYPH_W       = 16;
  localparam int DIG_W         = 2 * GLYPH_W;
  localparam int CFG_W         = 6;
  localparam int QUOT_W        = 5;
  localparam int KIDX_W        = $clog2(FRAME_BYTES);
  localparam logic [CODE_W-1:0] DIV_BASE = 8'd10;

  typedef enum logic [2:0] {
    OP_SET_RANGE = 3'd0,
    OP_CLR_RANGE = 3'd1,
    OP_DIGITS    = 3'd2,
    OP_SHOW_TIME = 3'd3,
    OP_CLR_ALL   = 3'd4,
    OP_SET_ALL   = 3'd5,
    OP_FLUSH     = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_A,
    ST_CHK_B,
    ST_ORDER,
    ST_WALK,
    ST_DIV,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    ALU_CHK_A,
    ALU_CHK_B,
    ALU_ORDER,
    ALU_WALK,
    ALU_DIV
  } alu_sel_t;

  typedef struct packed {
    logic [CODE_W-1:0] diff;
    logic              borrow;
    logic              zero;
  } alu_res_t;

  typedef struct packed {
    logic  in_valid;
    op_t   in_op;
    op_t   cur_op;
    logic  borrow;
    logic  zero;
    logic  flush_last;
    logic  out_free;
  } sts_t;

  typedef struct packed {
    logic     in_ready;
    logic     take;
    alu_sel_t alu_sel;
    logic     do_order;
    logic     walk_step;
    logic     div_step;
    logic     div_done;
    logic     flush_load;
  } ctl_t;

  // Segment font: low byte is the first segment byte, high byte the second.
  function automatic logic [GLYPH_W-1:0] glyph(input logic [CODE_W-1:0] code);
    logic [GLYPH_W-1:0] g;
    case (code)
      8'd0:  g = 16'h0FFF;
      8'd1:  g = 16'h003C;
      8'd2:  g = 16'h33CF;
      8'd3:  g = 16'h30FF;
      8'd4:  g = 16'h3C3C;
      8'd5:  g = 16'h3CF3;
      8'd6:  g = 16'h3FF3;
      8'd7:  g = 16'h003F;
      8'd8:  g = 16'h3FFF;
      8'd9:  g = 16'h3CFF;
      8'h41: g = 16'h3F3F; // A
      8'h42: g = 16'h1FDB;
      8'h43: g = 16'h0FC3;
      8'h44: g = 16'h0FDB;
      8'h45: g = 16'h3FC3;
      8'h46: g = 16'h3F03;
      8'h47: g = 16'h1FD3;
      8'h48: g = 16'h3F3C;
      8'h49: g = 16'h0F00;
      8'h4A: g = 16'h00FC;
      8'h4B: g = 16'h3F24;
      8'h4C: g = 16'h0FC0;
      8'h4D: g = 16'h3B34;
      8'h4E: g = 16'h073B;
      8'h4F: g = 16'h06DB;
      8'h50: g = 16'h3F0F;
      8'h52: g = 16'h0F03;
      8'h53: g = 16'h2CD1;
      8'h54: g = 16'h3F00;
      8'h55: g = 16'h0FFC;
      8'h56: g = 16'h0AD4;
      8'h59: g = 16'h3DFD;
      8'h5A: g = 16'h32D8; // Z
      default: g = '0;     // no glyph: blank
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/led_ring_and_digit_frame_controller_top.sv =====
// Top level of the LED ring and two-digit frame controller.
//
// Keeps a 96-bit frame for a chain of shift-register LED drivers: bytes 0-7
// carry a ring of RING_LEDS LEDs (position p is ring bit p-1, position 0 is
// the last ring bit), bytes 8-11 the segment patterns of two digits. Items
// arrive on a valid/stall channel and are taken one at a time; in_stall stays
// high until the current transaction's work is done. Digits, clear all, set
// all and the unused op are applied when the item is accepted. Set/clear
// range checks both ends against the ring size, orders them and walks from
// the low end to the high end, or drops the range when an end is off the
// ring; one bit is written per cycle by a sequencer that steps a position
// counter, with the single 8-bit shared subtractor doing the range checks,
// the ordering compare and the end test. Show time adds an hour split, done
// as repeated subtraction of ten on the same subtractor. Flush sends twelve
// bytes, byte 11 first, through one output register; latch_last marks byte
// 0, and an output stall holds back the next byte. The last byte may still
// wait in the output register while the next item is taken. range_start
// (reset 1) is written through cfg_wr_en/cfg_wr_data and should only change
// while idle.
`default_nettype none
`include "led_ring_and_digit_frame_controller_top_defines.svh"
module led_ring_and_digit_frame_controller_top
  import lrdf_pkg::*;
#(
  parameter int RING_LEDS = RING_LEDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_W-1:0]  cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        op,
  input  wire logic [CODE_W-1:0] pos_a,
  input  wire logic [CODE_W-1:0] pos_b,
  input  wire logic [CODE_W-1:0] left_code,
  input  wire logic [CODE_W-1:0] right_code,
  input  wire logic [CODE_W-1:0] minute,
  input  wire logic [CODE_W-1:0] hour,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CODE_W-1:0]      frame_byte,
  output logic                   latch_last
);

  localparam int RIDX_W = $clog2(RING_LEDS);
  localparam logic [CODE_W-1:0] RING_N = CODE_W'(RING_LEDS);
  localparam logic [RIDX_W-1:0] RING_TOP = RIDX_W'(RING_LEDS - 1);

  // Configuration and frame state
  logic [CFG_W-1:0]     range_start;
  logic [RING_LEDS-1:0] ring;
  logic [DIG_W-1:0]     digits;

  // Per-transaction working registers
  op_t                  cur_op;
  logic [CODE_W-1:0]    a_q, b_q, p_q, hi_q, rem_q;
  logic [QUOT_W-1:0]    quot_q;
  logic [KIDX_W-1:0]    k_q;

  sts_t                 sts;
  ctl_t                 ctl;
  alu_res_t             alu_res;
  logic [CODE_W-1:0]    alu_a, alu_b;
  logic [RIDX_W-1:0]    bit_idx;
  logic [RING_MAX-1:0]  ring_wide;
  logic [FRAME_W-1:0]   frame;
  logic                 out_free;

  lrdf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  lrdf_alu u_alu (
    .opa (alu_a),
    .opb (alu_b),
    .res (alu_res)
  );

  assign in_stall = !ctl.in_ready;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sts.in_valid   = in_valid;
    sts.in_op      = op_t'(op);
    sts.cur_op     = cur_op;
    sts.borrow     = alu_res.borrow;
    sts.zero       = alu_res.zero;
    sts.flush_last = (k_q == '0);
    sts.out_free   = out_free;
  end

  // Route operands into the shared subtractor for the current step.
  always_comb begin
    case (ctl.alu_sel)
      ALU_CHK_A: begin
        alu_a = a_q;
        alu_b = RING_N;
      end
      ALU_CHK_B: begin
        alu_a = b_q;
        alu_b = RING_N;
      end
      ALU_ORDER: begin
        alu_a = a_q;
        alu_b = b_q;
      end
      ALU_WALK: begin
        alu_a = hi_q;
        alu_b = p_q;
      end
      ALU_DIV: begin
        alu_a = rem_q;
        alu_b = DIV_BASE;
      end
      default: begin
        alu_a = rem_q;
        alu_b = DIV_BASE;
      end
    endcase
  end

  // Position 0 wraps to the last ring bit.
  assign bit_idx = (p_q == '0) ? RING_TOP : RIDX_W'(p_q - 8'd1);

  always_comb begin
    ring_wide                = '0;
    ring_wide[RING_LEDS-1:0] = ring;
  end

  assign frame = {digits, ring_wide};

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      range_start <= cfg_wr_data;
    end
  end

  // Latch the transaction; show time walks from range_start to minute.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cur_op <= op_t'(op);
      a_q    <= (op_t'(op) == OP_SHOW_TIME) ? CODE_W'(range_start) : pos_a;
      b_q    <= (op_t'(op) == OP_SHOW_TIME) ? minute : pos_b;
      rem_q  <= hour;
      quot_q <= '0;
      k_q    <= KIDX_W'(FRAME_BYTES - 1);
    end else begin
      if (ctl.do_order) begin
        // borrow means a < b
        p_q  <= alu_res.borrow ? a_q : b_q;
        hi_q <= alu_res.borrow ? b_q : a_q;
      end
      if (ctl.walk_step) begin
        p_q <= p_q + 8'd1;
      end
      if (ctl.div_step) begin
        rem_q  <= alu_res.diff;
        quot_q <= quot_q + QUOT_W'(1);
      end
      if (ctl.flush_load) begin
        k_q <= k_q - KIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring   <= '0;
      digits <= '0;
    end else begin
      if (ctl.take) begin
        case (op_t'(op))
          OP_CLR_ALL: ring   <= '0;
          OP_SET_ALL: ring   <= '1;
          OP_DIGITS:  digits <= {glyph(right_code), glyph(left_code)};
          default:    ring   <= ring;
        endcase
      end
      if (ctl.walk_step) begin
        ring[bit_idx] <= (cur_op != OP_CLR_RANGE);
      end
      if (ctl.div_done) begin
        digits <= {glyph(rem_q), glyph(CODE_W'(quot_q))};
      end
    end
  end

  // Output register: load the next frame byte, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.flush_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.flush_load) begin
      frame_byte <= frame[{k_q, 3'b000} +: 8];
      latch_last <= (k_q == '0);
    end
  end

  `LRDF_ASSERT_NOW(a_walk_bounds, clk, rst, ctl.walk_step,
                   (p_q <= hi_q) && (hi_q < RING_N), "ring walk left its range")
  `LRDF_ASSERT_NEXT(a_latch_on_last, clk, rst, ctl.flush_load && (k_q == '0),
                    out_valid && latch_last, "last flush byte not marked")
  `LRDF_ASSERT_NOW(a_quot_range, clk, rst, ctl.div_done,
                   (quot_q <= QUOT_W'(25)) && (rem_q < DIV_BASE), "hour split out of range")
  `LRDF_ASSERT_NOW(a_no_load_when_ready, clk, rst, !in_stall,
                   !ctl.flush_load && !ctl.walk_step, "busy work while accepting")

endmodule
`default_nettype wire

// ===== hdl/lrdf_alu.sv =====
// Shared 8-bit subtract and compare unit.
`default_nettype none
module lrdf_alu
  import lrdf_pkg::*;
(
  input  wire logic [CODE_W-1:0] opa,
  input  wire logic [CODE_W-1:0] opb,
  output alu_res_t               res
);

  logic [CODE_W:0] full;

  assign full       = {1'b0, opa} - {1'b0, opb};
  assign res.diff   = full[CODE_W-1:0];
  assign res.borrow = full[CODE_W];
  assign res.zero   = (full[CODE_W-1:0] == '0);

endmodule
`default_nettype wire

// ===== hdl/lrdf_ctrl.sv =====
// Command sequencer of the LED ring frame controller.
`default_nettype none
module lrdf_ctrl
  import lrdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  sts_t      sts,
  output ctl_t      ctl
);

  state_t state, state_next;
  op_t    done_op;

  assign done_op = sts.cur_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sts.in_valid) begin
          if (sts.in_op inside {OP_SET_RANGE, OP_CLR_RANGE, OP_SHOW_TIME}) begin
            state_next = ST_CHK_A;
          end else if (sts.in_op == OP_FLUSH) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_CHK_A, ST_CHK_B: begin
        // no borrow: end at or past ring size, drop the range
        if (!sts.borrow) begin
          state_next = (done_op == OP_SHOW_TIME) ? ST_DIV : ST_IDLE;
        end else begin
          state_next = (state == ST_CHK_A) ? ST_CHK_B : ST_ORDER;
        end
      end
      ST_ORDER: state_next = ST_WALK;
      ST_WALK: begin
        if (sts.zero) begin
          state_next = (done_op == OP_SHOW_TIME) ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts.borrow) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free && sts.flush_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.alu_sel    = ALU_DIV;
    ctl.in_ready   = (state == ST_IDLE);
    ctl.take       = ctl.in_ready && sts.in_valid;
    case (state)
      ST_CHK_A:  ctl.alu_sel = ALU_CHK_A;
      ST_CHK_B:  ctl.alu_sel = ALU_CHK_B;
      ST_ORDER: begin
        ctl.alu_sel  = ALU_ORDER;
        ctl.do_order = 1'b1;
      end
      ST_WALK: begin
        ctl.alu_sel   = ALU_WALK;
        ctl.walk_step = 1'b1;
      end
      ST_DIV: begin
        ctl.alu_sel  = ALU_DIV;
        ctl.div_step = !sts.borrow;
        ctl.div_done = sts.borrow;
      end
      ST_FLUSH:  ctl.flush_load = sts.out_free;
      default:   ctl.alu_sel = ALU_DIV;
    endcase
  end

endmodule
`default_nettype wire
